// ===== rtl/pslh_pkg.sv =====
package pslh_pkg;

   // Defaults for the top-level parameters.
   localparam int unsigned MAX_POINTS_DEF   = 4096;
   localparam int unsigned CORDIC_STEPS_DEF = 16;

   // Field widths of the point and result beats.
   localparam int unsigned COORD_W = 24;
   localparam int unsigned IDX_W   = 12;
   localparam int unsigned LEN_W   = 25;
   localparam int unsigned HEAD_W  = 15;
   localparam int unsigned SUM_W   = 37;

   // Datapath widths. A coordinate difference needs one bit more than a
   // coordinate; the sum of two squared differences stays below 2^49.
   localparam int unsigned DIFF_W = COORD_W + 1;
   localparam int unsigned SQ_W   = 2 * COORD_W;
   localparam int unsigned RAD_W  = 50;
   localparam int unsigned CRD_W  = 36;
   localparam int unsigned ANG_W  = 28;

   // One square-root bit is settled per cell, so the row has one cell per
   // root bit; this also covers the longest CORDIC pass of 24 iterations.
   localparam int unsigned SQRT_STEPS = 25;
   localparam int unsigned NUM_CELLS  = SQRT_STEPS;

   // Results that may be outstanding between issue and the result port.
   localparam int unsigned QUEUE_DEPTH = 4;

   // Angles: pi in Q.24 radians and in Q3.12 radians.
   localparam logic signed [ANG_W-1:0] PI_Q24 = 28'sd52707179;
   localparam logic signed [ANG_W-1:0] PI_Q12 = 28'sd12868;

   typedef enum logic {
      ST_ACCEPT,
      ST_CLOSE
   } state_type;

   // Bookkeeping that travels with a segment through the pipeline.
   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             last;
      logic             fresh;
      logic             zero;
   } tag_type;

   // Working values of the square root and of the CORDIC vectoring pass.
   typedef struct packed {
      logic [RAD_W-1:0]        rem;
      logic [RAD_W-1:0]        root;
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } cell_data_type;

   typedef struct packed {
      logic [IDX_W-1:0]         idx;
      logic [LEN_W-1:0]         len;
      logic signed [HEAD_W-1:0] heading;
      logic [SUM_W-1:0]         total;
      logic                     last;
   } result_type;

   // Arctangent of 2^-step in Q.24 radians, rounded to nearest.
   function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned step);
      logic signed [ANG_W-1:0] val;
      case (step)
         0:  val = 28'sd13176795;
         1:  val = 28'sd7778716;
         2:  val = 28'sd4110060;
         3:  val = 28'sd2086331;
         4:  val = 28'sd1047214;
         5:  val = 28'sd524117;
         6:  val = 28'sd262123;
         7:  val = 28'sd131069;
         8:  val = 28'sd65536;
         9:  val = 28'sd32768;
         10: val = 28'sd16384;
         11: val = 28'sd8192;
         12: val = 28'sd4096;
         13: val = 28'sd2048;
         14: val = 28'sd1024;
         15: val = 28'sd512;
         16: val = 28'sd256;
         17: val = 28'sd128;
         18: val = 28'sd64;
         19: val = 28'sd32;
         20: val = 28'sd16;
         21: val = 28'sd8;
         22: val = 28'sd4;
         23: val = 28'sd2;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/pslh_if.sv =====
// Point channel: one polyline point per beat.
interface pslh_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [pslh_pkg::COORD_W-1:0]   x_coord;
   logic signed [pslh_pkg::COORD_W-1:0]   y_coord;
   logic                                  last_point;

   modport source (output valid, x_coord, y_coord, last_point, input ready);
   modport sink   (input valid, x_coord, y_coord, last_point, output ready);
endinterface

// Result channel: one segment per beat.
interface pslh_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [pslh_pkg::IDX_W-1:0]            segment_index;
   logic [pslh_pkg::LEN_W-1:0]            segment_length;
   logic signed [pslh_pkg::HEAD_W-1:0]    heading;
   logic [pslh_pkg::SUM_W-1:0]            running_length;
   logic                                  last_of_curve;

   modport source (output valid, segment_index, segment_length, heading, running_length,
                   last_of_curve, input ready);
   modport sink   (input valid, segment_index, segment_length, heading, running_length,
                   last_of_curve, output ready);
endinterface

// Register write channel: the closed_curve control bit.
interface pslh_csr_if;
   logic valid;
   logic ready;
   logic closed_curve;

   modport source (output valid, closed_curve, input ready);
   modport sink   (input valid, closed_curve, output ready);
endinterface

// ===== rtl/pslh_prep.sv =====
module pslh_prep (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic signed [pslh_pkg::DIFF_W-1:0]     in_dx,
   input  logic signed [pslh_pkg::DIFF_W-1:0]     in_dy,
   input  pslh_pkg::tag_type                      in_tag,
   output logic                                   out_valid,
   output pslh_pkg::tag_type                      out_tag,
   output pslh_pkg::cell_data_type                out_data
);
   localparam int unsigned COORD_W = pslh_pkg::COORD_W;
   localparam int unsigned DIFF_W  = pslh_pkg::DIFF_W;
   localparam int unsigned SQ_W    = pslh_pkg::SQ_W;
   localparam int unsigned RAD_W   = pslh_pkg::RAD_W;
   localparam int unsigned CRD_W   = pslh_pkg::CRD_W;
   localparam int unsigned ANG_W   = pslh_pkg::ANG_W;

   logic signed [DIFF_W-1:0] neg_dx;
   logic signed [DIFF_W-1:0] neg_dy;
   logic signed [DIFF_W-1:0] y_sel;
   logic [COORD_W-1:0]       mag_x;
   logic [COORD_W-1:0]       mag_y;
   logic                     flip;

   logic                     s1_valid_ff;
   pslh_pkg::tag_type        s1_tag_ff;
   pslh_pkg::tag_type        s1_tag_in;
   logic [SQ_W-1:0]          s1_sqx_ff;
   logic [SQ_W-1:0]          s1_sqx_in;
   logic [SQ_W-1:0]          s1_sqy_ff;
   logic [SQ_W-1:0]          s1_sqy_in;
   logic signed [CRD_W-1:0]  s1_x_ff;
   logic signed [CRD_W-1:0]  s1_x_in;
   logic signed [CRD_W-1:0]  s1_y_ff;
   logic signed [CRD_W-1:0]  s1_y_in;
   logic signed [ANG_W-1:0]  s1_z_ff;
   logic signed [ANG_W-1:0]  s1_z_in;

   logic                     s2_valid_ff;
   pslh_pkg::tag_type        s2_tag_ff;
   pslh_pkg::cell_data_type  s2_data_ff;
   pslh_pkg::cell_data_type  s2_data_in;

   // Magnitudes for the squares, and the CORDIC start vector. A vector that
   // points left is turned by pi so the iterations start in the right half.
   always_comb begin
      neg_dx    = -in_dx;
      neg_dy    = -in_dy;
      flip      = in_dx[DIFF_W-1];
      mag_x     = flip ? neg_dx[COORD_W-1:0] : in_dx[COORD_W-1:0];
      mag_y     = in_dy[DIFF_W-1] ? neg_dy[COORD_W-1:0] : in_dy[COORD_W-1:0];
      y_sel     = flip ? neg_dy : in_dy;
      s1_sqx_in = mag_x * mag_x;
      s1_sqy_in = mag_y * mag_y;
      s1_x_in   = {{(CRD_W-COORD_W-8){1'b0}}, mag_x, 8'h00};
      s1_y_in   = {{(CRD_W-DIFF_W-8){y_sel[DIFF_W-1]}}, y_sel, 8'h00};
      if (flip) begin
         s1_z_in = in_dy[DIFF_W-1] ? -pslh_pkg::PI_Q24 : pslh_pkg::PI_Q24;
      end else begin
         s1_z_in = '0;
      end
      s1_tag_in      = in_tag;
      s1_tag_in.zero = (in_dx == '0) && (in_dy == '0);
   end

   // Sum of squares starts the root; the root itself starts at zero.
   always_comb begin
      s2_data_in.rem  = RAD_W'(s1_sqx_ff) + RAD_W'(s1_sqy_ff);
      s2_data_in.root = '0;
      s2_data_in.x    = s1_x_ff;
      s2_data_in.y    = s1_y_ff;
      s2_data_in.z    = s1_z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff  <= s1_tag_in;
      s1_sqx_ff  <= s1_sqx_in;
      s1_sqy_ff  <= s1_sqy_in;
      s1_x_ff    <= s1_x_in;
      s1_y_ff    <= s1_y_in;
      s1_z_ff    <= s1_z_in;
      s2_tag_ff  <= s1_tag_ff;
      s2_data_ff <= s2_data_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_tag   = s2_tag_ff;
   assign out_data  = s2_data_ff;

endmodule

// ===== rtl/pslh_cell.sv =====
module pslh_cell #(
   parameter int unsigned IDX          = 0,
   parameter int unsigned CORDIC_STEPS = pslh_pkg::CORDIC_STEPS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  pslh_pkg::tag_type         in_tag,
   input  pslh_pkg::cell_data_type   in_data,
   output logic                      out_valid,
   output pslh_pkg::tag_type         out_tag,
   output pslh_pkg::cell_data_type   out_data
);
   localparam int unsigned RAD_W    = pslh_pkg::RAD_W;
   localparam int unsigned CRD_W    = pslh_pkg::CRD_W;
   localparam int unsigned ANG_W    = pslh_pkg::ANG_W;
   localparam int unsigned SQ_SHIFT = 2 * (pslh_pkg::SQRT_STEPS - 1 - IDX);
   localparam logic [RAD_W-1:0] SQ_BIT = {{(RAD_W-1){1'b0}}, 1'b1} << SQ_SHIFT;
   localparam logic              CRD_ON = (IDX < CORDIC_STEPS);
   localparam logic signed [ANG_W-1:0] ATAN = pslh_pkg::atan_entry(IDX);

   logic [RAD_W:0]           trial;
   logic signed [CRD_W-1:0]  x_cur;
   logic signed [CRD_W-1:0]  y_cur;
   logic signed [CRD_W-1:0]  x_sh;
   logic signed [CRD_W-1:0]  y_sh;
   logic                     valid_ff;
   pslh_pkg::tag_type        tag_ff;
   pslh_pkg::cell_data_type  data_ff;
   pslh_pkg::cell_data_type  data_in;

   always_comb begin
      data_in = in_data;

      // One bit of the integer square root.
      trial = {1'b0, in_data.root} + {1'b0, SQ_BIT};
      if ({1'b0, in_data.rem} >= trial) begin
         data_in.rem  = in_data.rem - trial[RAD_W-1:0];
         data_in.root = (in_data.root >> 1) + SQ_BIT;
      end else begin
         data_in.root = in_data.root >> 1;
      end

      // One CORDIC vectoring iteration; a zero y rotates as if positive.
      x_cur = in_data.x;
      y_cur = in_data.y;
      x_sh  = x_cur >>> IDX;
      y_sh  = y_cur >>> IDX;
      if (CRD_ON) begin
         if (!y_cur[CRD_W-1]) begin
            data_in.x = x_cur + y_sh;
            data_in.y = y_cur - x_sh;
            data_in.z = in_data.z + ATAN;
         end else begin
            data_in.x = x_cur - y_sh;
            data_in.y = y_cur + x_sh;
            data_in.z = in_data.z - ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= in_tag;
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/pslh_finish.sv =====
module pslh_finish (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  pslh_pkg::tag_type         in_tag,
   input  pslh_pkg::cell_data_type   in_data,
   output logic                      out_valid,
   output pslh_pkg::result_type      out_result
);
   localparam int unsigned LEN_W  = pslh_pkg::LEN_W;
   localparam int unsigned HEAD_W = pslh_pkg::HEAD_W;
   localparam int unsigned SUM_W  = pslh_pkg::SUM_W;
   localparam int unsigned ANG_W  = pslh_pkg::ANG_W;
   localparam logic signed [ANG_W-1:0] HALF_LSB = 28'sd2048;
   localparam logic signed [ANG_W-1:0] HEAD_MAX = pslh_pkg::PI_Q12;
   localparam logic signed [ANG_W-1:0] HEAD_MIN = -pslh_pkg::PI_Q12;

   logic                     round_up;
   logic [LEN_W-1:0]         len_in;
   logic signed [ANG_W-1:0]  z_round;
   logic signed [ANG_W-1:0]  z_q12;
   logic signed [ANG_W-1:0]  z_clamp;
   logic [SUM_W-1:0]         sum_base;
   logic [SUM_W:0]           sum_wide;
   logic [SUM_W-1:0]         sum_ff;
   logic [SUM_W-1:0]         sum_in;
   logic                     valid_ff;
   pslh_pkg::result_type     result_ff;
   pslh_pkg::result_type     result_in;

   // Round the root to nearest: the remainder exceeds the root past a half.
   always_comb begin
      round_up = (in_data.rem > in_data.root);
      len_in   = in_data.root[LEN_W-1:0] + {{(LEN_W-1){1'b0}}, round_up};
   end

   // Angle from Q.24 to Q3.12 with rounding, clamped to plus or minus pi.
   always_comb begin
      z_round = in_data.z + HALF_LSB;
      z_q12   = z_round >>> 12;
      if (z_q12 > HEAD_MAX) begin
         z_clamp = HEAD_MAX;
      end else if (z_q12 < HEAD_MIN) begin
         z_clamp = HEAD_MIN;
      end else begin
         z_clamp = z_q12;
      end
   end

   // Running curve length; the first segment of a curve starts it over.
   always_comb begin
      sum_base = in_tag.fresh ? '0 : sum_ff;
      sum_wide = {1'b0, sum_base} + {{(SUM_W+1-LEN_W){1'b0}}, len_in};
      sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
   end

   always_comb begin
      result_in.idx     = in_tag.idx;
      result_in.len     = len_in;
      result_in.heading = in_tag.zero ? '0 : z_clamp[HEAD_W-1:0];
      result_in.total   = sum_in;
      result_in.last    = in_tag.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sum_ff   <= '0;
      end else begin
         valid_ff <= in_valid;
         if (in_valid) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ===== rtl/pslh_queue.sv =====
module pslh_queue #(
   parameter int unsigned DEPTH = pslh_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pslh_pkg::result_type   push_data,
   input  logic                   pop,
   output logic                   valid,
   output pslh_pkg::result_type   data
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   pslh_pkg::result_type entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   // Pointer wrap and fill level.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign valid = (count_ff != '0);
   assign data  = entry_ff[rd_ptr_ff];

endmodule

// ===== rtl/polyline_segment_length_heading_top.sv =====
// Segment length and heading of a 2D polyline. Points arrive one per beat
// as signed Q16.8 coordinates, the last point of a curve marked; every point
// after the first yields one result beat with the segment index, the rounded
// Euclidean length (Q.8), the heading atan2(dy,dx) in Q3.12 radians and the
// saturating running length of the curve. With closed_curve set, the last
// point yields a second beat for the closing segment, index 0. Each segment
// runs through a row of 25 cells, each settling one root bit and, in the
// first CORDIC_STEPS cells, one CORDIC iteration. Between a taken point and
// the result port lie the issue register, the preparation stages, the row
// of cells, the finishing register and the result queue. Points are taken
// in consecutive cycles while fewer than three results are outstanding in
// the four-beat result queue, so new points enter before earlier ones finish;
// a closing point holds off the input while its closing segment is issued.
// The closed_curve bit is sampled when the last point is taken.
module polyline_segment_length_heading_top #(
   parameter int unsigned MAX_POINTS   = pslh_pkg::MAX_POINTS_DEF,
   parameter int unsigned CORDIC_STEPS = pslh_pkg::CORDIC_STEPS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   pslh_req_if.sink      req_if,
   pslh_rsp_if.source    rsp_if,
   pslh_csr_if.sink      csr_if
);
   localparam int unsigned COORD_W   = pslh_pkg::COORD_W;
   localparam int unsigned DIFF_W    = pslh_pkg::DIFF_W;
   localparam int unsigned IDX_W     = pslh_pkg::IDX_W;
   localparam int unsigned NUM_CELLS = pslh_pkg::NUM_CELLS;
   localparam int unsigned DEPTH     = pslh_pkg::QUEUE_DEPTH;
   localparam int unsigned CNT_W     = $clog2(MAX_POINTS);
   localparam int unsigned PEND_W    = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_POINTS - 1);
   localparam logic [PEND_W-1:0] PEND_LIMIT = PEND_W'(DEPTH - 2);
   localparam logic [PEND_W-1:0] PEND_FULL  = PEND_W'(DEPTH);

   pslh_pkg::state_type        state_ff;
   pslh_pkg::state_type        state_in;
   logic [CNT_W-1:0]           cnt_ff;
   logic [CNT_W-1:0]           cnt_in;
   logic                       fresh_ff;
   logic                       fresh_in;
   logic                       closed_ff;
   logic signed [COORD_W-1:0]  prev_x_ff;
   logic signed [COORD_W-1:0]  prev_x_in;
   logic signed [COORD_W-1:0]  prev_y_ff;
   logic signed [COORD_W-1:0]  prev_y_in;
   logic signed [COORD_W-1:0]  start_x_ff;
   logic signed [COORD_W-1:0]  start_x_in;
   logic signed [COORD_W-1:0]  start_y_ff;
   logic signed [COORD_W-1:0]  start_y_in;
   logic [PEND_W-1:0]          pend_ff;
   logic [PEND_W-1:0]          pend_in;

   logic                       req_fire;
   logic                       rsp_fire;
   logic                       csr_fire;
   logic                       req_ready;
   logic                       first_point;
   logic                       close_now;

   logic                       iss_valid_in;
   logic signed [DIFF_W-1:0]   iss_dx_in;
   logic signed [DIFF_W-1:0]   iss_dy_in;
   pslh_pkg::tag_type          iss_tag_in;
   logic                       iss_valid_ff;
   logic signed [DIFF_W-1:0]   iss_dx_ff;
   logic signed [DIFF_W-1:0]   iss_dy_ff;
   pslh_pkg::tag_type          iss_tag_ff;

   logic                       chain_valid [NUM_CELLS+1];
   pslh_pkg::tag_type          chain_tag   [NUM_CELLS+1];
   pslh_pkg::cell_data_type    chain_data  [NUM_CELLS+1];

   logic                       res_valid;
   pslh_pkg::result_type       res_data;
   logic                       q_valid;
   pslh_pkg::result_type       q_data;

   assign req_fire    = req_if.valid && req_ready;
   assign rsp_fire    = rsp_if.valid && rsp_if.ready;
   assign csr_fire    = csr_if.valid && csr_if.ready;
   assign first_point = (cnt_ff == '0);
   assign close_now   = req_fire && req_if.last_point && !first_point && closed_ff;

   // Next state: after a closing point, the closing state issues the closing
   // segment from the stored start point.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pslh_pkg::ST_ACCEPT: begin
            if (close_now) begin
               state_in = pslh_pkg::ST_CLOSE;
            end
         end
         pslh_pkg::ST_CLOSE: begin
            state_in = pslh_pkg::ST_ACCEPT;
         end
         default: begin
            state_in = pslh_pkg::ST_ACCEPT;
         end
      endcase
   end

   // Outputs of the sequencer: input ready and the segment to issue. A point
   // is taken only when both of its possible results are sure of a slot.
   always_comb begin
      req_ready    = 1'b0;
      iss_valid_in = 1'b0;
      iss_dx_in    = '0;
      iss_dy_in    = '0;
      iss_tag_in   = '0;
      case (state_ff)
         pslh_pkg::ST_ACCEPT: begin
            req_ready = (pend_ff <= PEND_LIMIT);
            if (req_if.valid && req_ready) begin
               if (first_point) begin
                  // A lone point gives one result, all zero but for its last flag.
                  iss_valid_in     = req_if.last_point;
                  iss_tag_in.idx   = '0;
                  iss_tag_in.last  = 1'b1;
                  iss_tag_in.fresh = 1'b1;
               end else begin
                  iss_valid_in     = 1'b1;
                  iss_dx_in        = {req_if.x_coord[COORD_W-1], req_if.x_coord}
                                   - {prev_x_ff[COORD_W-1], prev_x_ff};
                  iss_dy_in        = {req_if.y_coord[COORD_W-1], req_if.y_coord}
                                   - {prev_y_ff[COORD_W-1], prev_y_ff};
                  iss_tag_in.idx   = IDX_W'(cnt_ff);
                  iss_tag_in.last  = req_if.last_point && !closed_ff;
                  iss_tag_in.fresh = fresh_ff;
               end
            end
         end
         pslh_pkg::ST_CLOSE: begin
            // Closing segment: from the last point back to the first.
            iss_valid_in     = 1'b1;
            iss_dx_in        = {start_x_ff[COORD_W-1], start_x_ff}
                             - {prev_x_ff[COORD_W-1], prev_x_ff};
            iss_dy_in        = {start_y_ff[COORD_W-1], start_y_ff}
                             - {prev_y_ff[COORD_W-1], prev_y_ff};
            iss_tag_in.idx   = '0;
            iss_tag_in.last  = 1'b1;
            iss_tag_in.fresh = 1'b0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Curve state: previous point, start point and point count.
   always_comb begin
      cnt_in     = cnt_ff;
      fresh_in   = fresh_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      if (req_fire) begin
         prev_x_in = req_if.x_coord;
         prev_y_in = req_if.y_coord;
         if (first_point) begin
            start_x_in = req_if.x_coord;
            start_y_in = req_if.y_coord;
            if (!req_if.last_point) begin
               cnt_in   = {{(CNT_W-1){1'b0}}, 1'b1};
               fresh_in = 1'b1;
            end
         end else begin
            fresh_in = 1'b0;
            if (req_if.last_point) begin
               cnt_in = '0;
            end else if (cnt_ff < CNT_MAX) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
      end
   end

   // Results issued and not yet delivered.
   always_comb begin
      pend_in = pend_ff;
      if (iss_valid_in && !rsp_fire) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_fire && !iss_valid_in) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pslh_pkg::ST_ACCEPT;
         cnt_ff       <= '0;
         fresh_ff     <= 1'b0;
         closed_ff    <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         pend_ff      <= '0;
         iss_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fresh_ff     <= fresh_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         pend_ff      <= pend_in;
         iss_valid_ff <= iss_valid_in;
         if (csr_fire) begin
            closed_ff <= csr_if.closed_curve;
         end
      end
   end

   always_ff @(posedge clock) begin
      iss_dx_ff  <= iss_dx_in;
      iss_dy_ff  <= iss_dy_in;
      iss_tag_ff <= iss_tag_in;
   end

   // Squares and CORDIC start vector.
   pslh_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (iss_valid_ff),
      .in_dx     (iss_dx_ff),
      .in_dy     (iss_dy_ff),
      .in_tag    (iss_tag_ff),
      .out_valid (chain_valid[0]),
      .out_tag   (chain_tag[0]),
      .out_data  (chain_data[0])
   );

   // Row of cells, one root bit each and one rotation in each of the first CORDIC_STEPS.
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      pslh_cell #(
         .IDX          (k),
         .CORDIC_STEPS (CORDIC_STEPS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_tag    (chain_tag[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_tag   (chain_tag[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   // Rounding, heading and running total.
   pslh_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[NUM_CELLS]),
      .in_tag     (chain_tag[NUM_CELLS]),
      .in_data    (chain_data[NUM_CELLS]),
      .out_valid  (res_valid),
      .out_result (res_data)
   );

   pslh_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .pop       (rsp_fire),
      .valid     (q_valid),
      .data      (q_data)
   );

   assign req_if.ready          = req_ready;
   assign csr_if.ready          = 1'b1;
   assign rsp_if.valid          = q_valid;
   assign rsp_if.segment_index  = q_data.idx;
   assign rsp_if.segment_length = q_data.len;
   assign rsp_if.heading        = q_data.heading;
   assign rsp_if.running_length = q_data.total;
   assign rsp_if.last_of_curve  = q_data.last;

   // The credit count never passes the queue size.
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_FULL)
      else $error("outstanding result count above queue size");

   // A result beat on the port is always covered by a credit.
   a_rsp_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (pend_ff != '0))
      else $error("result beat without outstanding credit");

   // Taking a closing point moves to the closing-segment cycle.
   a_close_seq: assert property (@(posedge clock) disable iff (reset)
      close_now |=> (state_ff == pslh_pkg::ST_CLOSE) && !req_if.ready)
      else $error("closing segment not issued after closing point");

   // Heading stays within plus or minus pi.
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.heading <= 15'sd12868) && (rsp_if.heading >= -15'sd12868))
      else $error("heading out of range");

endmodule

// ===== tb/tb_polyline_segment_length_heading_top.sv =====
module tb_polyline_segment_length_heading_top;

   localparam int unsigned IDLE_PCT          = 37;
   localparam int unsigned SETTLE_CYCLES     = 48;
   localparam int unsigned WATCHDOG_LIMIT    = 5000;
   localparam int unsigned RANDOM_POINTS     = 1220;
   localparam int unsigned LONG_CURVE_POINTS = 300;
   localparam int unsigned STALL_CYCLES      = 300;
   localparam int unsigned MAX_REPORTS       = 40;
   localparam int unsigned COORD_W           = pslh_pkg::COORD_W;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam longint unsigned TOTAL_MAX = (64'd1 << pslh_pkg::SUM_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pslh_req_if req_ch ();
   pslh_rsp_if rsp_ch ();
   pslh_csr_if csr_ch ();

   polyline_segment_length_heading_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Free-running clock, period of two time units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow state of the block, advanced at every accepted point beat.
   logic signed [COORD_W-1:0] prev_x, prev_y, start_x, start_y;
   int unsigned               point_count;
   longint unsigned           curve_total;
   logic                      closed_mode;
   pslh_pkg::result_type      expected_segments[$];

   int unsigned req_idle_pct = IDLE_PCT;
   int unsigned rsp_idle_pct = IDLE_PCT;
   int unsigned stall_request = 0;
   int unsigned points_sent = 0;
   int unsigned segments_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;

   // Integer square root of the squared length, rounded to nearest.
   function automatic longint unsigned rounded_root(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 50;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (v > r) r = r + 1;
      return r;
   endfunction

   // Vectoring CORDIC on the scaled difference; angle kept in Q.24 radians.
   function automatic logic signed [pslh_pkg::HEAD_W-1:0] cordic_heading(input longint dx,
                                                                         input longint dy);
      longint x, y, z, nx, ny, h, step_angle, angle_pi, head_max;
      angle_pi = longint'(4.0 * $atan(1.0) * 16777216.0);
      head_max = longint'(4.0 * $atan(1.0) * 4096.0);
      if (dx == 0 && dy == 0) return '0;
      if (dx < 0) begin
         x = -dx * 256;
         y = -dy * 256;
         z = (dy >= 0) ? angle_pi : -angle_pi;
      end else begin
         x = dx * 256;
         y = dy * 256;
         z = 0;
      end
      for (int i = 0; i < int'(pslh_pkg::CORDIC_STEPS_DEF); i++) begin
         step_angle = longint'($atan(1.0 / (2.0 ** i)) * 16777216.0);
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z  = z + step_angle;
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z  = z - step_angle;
         end
         x = nx;
         y = ny;
      end
      h = (z + 2048) >>> 12;
      if (h > head_max) h = head_max;
      if (h < -head_max) h = -head_max;
      return h[pslh_pkg::HEAD_W-1:0];
   endfunction

   // Expected beat for the segment from point a to point b.
   function automatic void push_segment(input int unsigned index,
                                        input logic signed [COORD_W-1:0] ax, ay, bx, by,
                                        input logic is_last);
      longint dx, dy;
      longint unsigned len;
      pslh_pkg::result_type seg;
      dx = longint'(bx) - longint'(ax);
      dy = longint'(by) - longint'(ay);
      len = rounded_root(unsigned'(dx * dx + dy * dy));
      curve_total = curve_total + len;
      if (curve_total > TOTAL_MAX) curve_total = TOTAL_MAX;
      seg.idx     = index[pslh_pkg::IDX_W-1:0];
      seg.len     = len[pslh_pkg::LEN_W-1:0];
      seg.heading = cordic_heading(dx, dy);
      seg.total   = curve_total[pslh_pkg::SUM_W-1:0];
      seg.last    = is_last;
      expected_segments = {expected_segments, seg};
   endfunction

   // Advance the shadow state by one accepted point.
   function automatic void advance_polyline(input logic signed [COORD_W-1:0] x, y,
                                            input logic is_last);
      pslh_pkg::result_type lone;
      if (point_count == 0) begin
         start_x = x;
         start_y = y;
         prev_x = x;
         prev_y = y;
         curve_total = 0;
         if (is_last) begin
            // A curve of one point gives a single beat, all zero but for its last flag.
            lone = '0;
            lone.last = 1'b1;
            expected_segments = {expected_segments, lone};
         end else begin
            point_count = 1;
         end
         return;
      end
      push_segment(point_count, prev_x, prev_y, x, y, is_last && !closed_mode);
      prev_x = x;
      prev_y = y;
      if (point_count < pslh_pkg::MAX_POINTS_DEF - 1) point_count++;
      if (is_last) begin
         if (closed_mode) push_segment(0, x, y, start_x, start_y, 1'b1);
         point_count = 0;
         curve_total = 0;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
   endtask

   // Send one point beat; valid stays high into the next call unless it idles.
   task automatic send_point(input logic signed [COORD_W-1:0] x, y, input logic is_last);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.x_coord    <= x;
      req_ch.y_coord    <= y;
      req_ch.last_point <= is_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      advance_polyline(x, y, is_last);
      points_sent++;
   endtask

   // Drop valid, wait for every expected beat, then let the pipeline empty.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_closed(input logic value);
      @(negedge clock);
      csr_ch.valid        <= 1'b1;
      csr_ch.closed_curve <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      closed_mode = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Random coordinate: extremes, full range, zero, the last one again, or a small step from it.
   function automatic logic signed [COORD_W-1:0] pick_coord(
         input logic signed [COORD_W-1:0] near);
      logic signed [COORD_W-1:0] step;
      step = COORD_W'($urandom_range(1023)) - COORD_W'(512);
      case ($urandom_range(9))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2, 3:    return COORD_W'($urandom);
         8:       return near;
         9:       return '0;
         default: return near + step;
      endcase
   endfunction

   // Receiver ready: random stalls, or a counted hold-off when one is requested.
   always @(negedge clock) begin
      if (stall_request != 0) begin
         quiet_cycles = 0;
      end
   end

   int unsigned stall_left = 0;
   always @(negedge clock) begin
      if (stall_request != 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      pslh_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         segments_seen++;
         if (expected_segments.size() == 0) begin
            report_mismatch($sformatf("unexpected beat, segment_index %0d",
                                      rsp_ch.segment_index));
         end else begin
            want = expected_segments.pop_front();
            if (rsp_ch.segment_index !== want.idx)
               report_mismatch($sformatf("beat %0d segment_index %0d, want %0d",
                                         segments_seen, rsp_ch.segment_index, want.idx));
            if (rsp_ch.segment_length !== want.len)
               report_mismatch($sformatf("beat %0d segment_length %0d, want %0d",
                                         segments_seen, rsp_ch.segment_length, want.len));
            if (rsp_ch.heading !== want.heading)
               report_mismatch($sformatf("beat %0d heading %0d, want %0d",
                                         segments_seen, rsp_ch.heading, want.heading));
            if (rsp_ch.running_length !== want.total)
               report_mismatch($sformatf("beat %0d running_length %0d, want %0d",
                                         segments_seen, rsp_ch.running_length, want.total));
            if (rsp_ch.last_of_curve !== want.last)
               report_mismatch($sformatf("beat %0d last_of_curve %0b, want %0b",
                                         segments_seen, rsp_ch.last_of_curve, want.last));
         end
      end
   end

   // Watchdog: end the run when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, expected_segments.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Single-point curves and open curves over the four axis directions, the first three quadrants and the extremes.
   task automatic test_open_curves();
      write_closed(1'b0);
      send_point('0, '0, 1'b1);
      send_point(COORD_MAX, COORD_MIN, 1'b1);
      send_point('0, '0, 1'b0);
      send_point(24'sd256, '0, 1'b0);
      send_point(24'sd256, 24'sd256, 1'b0);
      send_point('0, 24'sd256, 1'b0);
      send_point('0, '0, 1'b0);
      send_point('0, '0, 1'b0);
      send_point(-24'sd256, -24'sd256, 1'b0);
      send_point(COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MAX, 1'b0);
      send_point(COORD_MAX, COORD_MIN, 1'b0);
      send_point(COORD_MIN, COORD_MAX, 1'b1);
   endtask

   // Closing segments, and register changes made while a curve is half sent.
   task automatic test_closed_curves();
      settle();
      write_closed(1'b1);
      send_point('0, '0, 1'b0);
      send_point(24'sd512, '0, 1'b0);
      send_point(24'sd512, 24'sd512, 1'b1);
      send_point(COORD_MIN, COORD_MAX, 1'b1);
      send_point(24'sd100, 24'sd100, 1'b0);
      send_point(-24'sd300, 24'sd700, 1'b0);
      settle();
      write_closed(1'b0);
      send_point(24'sd5, 24'sd5, 1'b1);
      send_point(24'sd7, -24'sd9, 1'b0);
      send_point(24'sd1000, 24'sd2000, 1'b0);
      settle();
      write_closed(1'b1);
      send_point(-24'sd50, 24'sd60, 1'b1);
   endtask

   // Receiver holds off while points keep coming, so the block fills and stalls.
   task automatic test_receiver_stall();
      logic signed [COORD_W-1:0] x, y;
      settle();
      write_closed(1'b0);
      req_idle_pct = 0;
      stall_request = STALL_CYCLES;
      x = '0;
      y = '0;
      for (int k = 1; k <= 40; k++) begin
         x = pick_coord(x);
         y = pick_coord(y);
         send_point(x, y, k == 40);
      end
      req_idle_pct = IDLE_PCT;
   endtask

   // Zigzag between opposite corners: the longest segments and a large total.
   task automatic test_long_zigzag_curve();
      settle();
      write_closed(1'b1);
      for (int unsigned k = 0; k < LONG_CURVE_POINTS; k++) begin
         if (k[0]) send_point(COORD_MAX, COORD_MAX, k == LONG_CURVE_POINTS - 1);
         else      send_point(COORD_MIN, COORD_MIN, k == LONG_CURVE_POINTS - 1);
      end
   endtask

   // Random curves in phases, each phase with its own register setting.
   task automatic test_random_curves();
      int unsigned sent, phase, curves, len, pick;
      logic signed [COORD_W-1:0] x, y;
      sent = 0;
      phase = 0;
      x = '0;
      y = '0;
      while (sent < RANDOM_POINTS) begin
         settle();
         if (phase < 2) write_closed(phase[0]);
         else           write_closed(1'($urandom_range(1)));
         // One long phase runs with neither side idling.
         if (phase == 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
            curves = 40;
         end else begin
            req_idle_pct = IDLE_PCT;
            rsp_idle_pct = IDLE_PCT;
            curves = $urandom_range(4, 14);
         end
         repeat (curves) begin
            pick = $urandom_range(99);
            if (pick < 70)      len = $urandom_range(1, 8);
            else if (pick < 95) len = $urandom_range(9, 40);
            else                len = $urandom_range(41, 120);
            for (int unsigned k = 1; k <= len; k++) begin
               x = pick_coord(x);
               y = pick_coord(y);
               send_point(x, y, k == len);
            end
            sent += len;
         end
         phase++;
      end
      req_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;
   endtask

   task automatic finish_run();
      settle();
      while (expected_segments.size() != 0) begin
         report_mismatch($sformatf("segment_index %0d never arrived",
                                   expected_segments[0].idx));
         void'(expected_segments.pop_front());
      end
      $display("Run covered %0d points and %0d segment beats with closed_curve 0 and 1,",
               points_sent, segments_seen);
      $display("a %0d-point zigzag curve and a %0d-cycle receiver hold-off; %0d mismatches.",
               LONG_CURVE_POINTS, STALL_CYCLES, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   endtask

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.x_coord      = '0;
      req_ch.y_coord      = '0;
      req_ch.last_point   = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.closed_curve = 1'b0;
      prev_x      = '0;
      prev_y      = '0;
      start_x     = '0;
      start_y     = '0;
      point_count = 0;
      curve_total = 0;
      closed_mode = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_open_curves();
      test_closed_curves();
      test_receiver_stall();
      test_long_zigzag_curve();
      test_random_curves();
      finish_run();
   end

endmodule

// ===== files.f =====
rtl/pslh_pkg.sv
rtl/pslh_if.sv
rtl/pslh_prep.sv
rtl/pslh_cell.sv
rtl/pslh_finish.sv
rtl/pslh_queue.sv
rtl/polyline_segment_length_heading_top.sv
tb/tb_polyline_segment_length_heading_top.sv
